// File: hw/rtl/srp_pkg.sv
// Shared types and constants of the skyline rectangle packer.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package srp_pkg;

    // Fixed field widths of the item and result words
    localparam int IN_W  = 16;
    localparam int PX_W  = 10;
    localparam int PY_W  = 12;
    localparam int AH_W  = 13;
    localparam int ST_W  = 2;

    // Padding and smallest reported atlas height
    localparam int PAD_TOTAL      = 2;
    localparam int MIN_TEX_HEIGHT = 64;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic decide;
        logic start_pass;
        logic scan;
        logic set_exh;
        logic wr_init;
        logic write;
        logic clear;
        logic fin;
        logic pow;
        logic load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic skip;
        logic bad;
        logic lo_lt_hi;
        logic have;
        logic pass_done;
        logic wr_done;
        logic clr_done;
        logic need_pow;
        logic pow_done;
        logic out_busy;
        logic last;
    } t_sts;

endpackage

// File: hw/rtl/srp_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module srp_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/srp_ctrl.sv
// Sequencer of the skyline packer: clear sweep, threshold search passes,
// skyline update, height rounding and result hand-off. Uses srp_pkg.
`timescale 1ns / 1ps

module srp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  srp_pkg::t_sts i_sts,
    output srp_pkg::t_cmd o_cmd
);
    import srp_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_STEP   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_WRITE  = 4'd5;
    localparam logic [3:0] S_FIN    = 4'd6;
    localparam logic [3:0] S_POW    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                n_state    = (i_sts.skip || i_sts.bad) ? S_FIN : S_STEP;
            end
            S_STEP: begin
                if (i_sts.lo_lt_hi) begin
                    cmd.start_pass = 1'b1;
                    n_state        = S_SCAN;
                end else if (i_sts.have) begin
                    cmd.wr_init = 1'b1;
                    n_state     = S_WRITE;
                end else begin
                    cmd.set_exh = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_sts.pass_done) n_state = S_STEP;
            end
            S_WRITE: begin
                cmd.write = 1'b1;
                if (i_sts.wr_done) n_state = S_FIN;
            end
            S_FIN: begin
                cmd.fin = 1'b1;
                n_state = i_sts.need_pow ? S_POW : S_OUT;
            end
            S_POW: begin
                cmd.pow = 1'b1;
                if (i_sts.pow_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    n_state      = i_sts.last ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);

endmodule

// File: hw/rtl/srp_dp.sv
// Datapath of the skyline packer: skyline RAM, search bounds, run counter,
// batch state and the result word register. Uses srp_pkg and srp_ram.
`timescale 1ns / 1ps

module srp_dp #(
    parameter int TEX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  srp_pkg::t_cmd             i_cmd,
    output srp_pkg::t_sts             o_sts,
    input  logic [srp_pkg::IN_W-1:0]  i_rect_width,
    input  logic [srp_pkg::IN_W-1:0]  i_rect_height,
    input  logic                      i_last,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [srp_pkg::PX_W-1:0]  o_place_x,
    output logic [srp_pkg::PY_W-1:0]  o_place_y,
    output logic                      o_active,
    output logic [srp_pkg::ST_W-1:0]  o_status,
    output logic [srp_pkg::AH_W-1:0]  o_tex_height,
    output logic                      o_result_last
);
    import srp_pkg::*;

    localparam int AW = $clog2(TEX_WIDTH);
    localparam int CW = $clog2(TEX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Item and search registers
    logic [IN_W-1:0] r_w, r_h;
    logic            r_last;
    logic [HW-1:0]   r_lo, r_hi;
    logic            r_have;
    logic [AW-1:0]   r_best_x;
    logic [CW-1:0]   r_addr, r_run;
    logic            r_rd_vld;
    logic [AW-1:0]   r_rd_idx;
    // Batch state
    logic [HW-1:0]   r_uh;
    logic [ST_W-1:0] r_err;
    logic [HW:0]     r_pow;
    // Per-item result and output word
    logic [PX_W-1:0] r_px, r_opx;
    logic [PY_W-1:0] r_py, r_opy;
    logic            r_act, r_oact;
    logic [AH_W-1:0] r_ah, r_oah;
    logic [ST_W-1:0] r_ost;
    logic            r_olast, r_ovalid;

    logic [CW-1:0]   pw;
    logic [HW-1:0]   ph, hi_init, mid, top, rdata;
    logic            is_zero, skip, bad, le, hit, pass_end, addr_in;
    logic [CW-1:0]   run_inc;
    logic [AW-1:0]   hit_x;
    logic            wr_done, clr_done;

    // Padded sizes and entry checks
    assign pw      = CW'(r_w) + CW'(PAD_TOTAL);
    assign ph      = HW'(r_h) + HW'(PAD_TOTAL);
    assign is_zero = (r_w == '0) && (r_h == '0);
    assign skip    = (r_err != ST_OK) || is_zero;
    assign bad     = (r_w == '0) || (r_h == '0)
                   || (32'(r_w) > 32'(TEX_WIDTH - PAD_TOTAL))
                   || (32'(r_h) > 32'(MAX_HEIGHT - PAD_TOTAL));
    assign hi_init = HW'(MAX_HEIGHT) - ph + HW'(1);

    // Threshold pass: run of columns at or below mid
    assign mid      = HW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign le       = (rdata <= mid);
    assign run_inc  = r_run + CW'(1);
    assign hit      = r_rd_vld && le && (run_inc == pw);
    assign pass_end = r_rd_vld && !hit && (r_rd_idx == AW'(TEX_WIDTH - 1));
    assign hit_x    = AW'(CW'(r_rd_idx) + CW'(1) - pw);
    assign addr_in  = (r_addr != CW'(TEX_WIDTH));

    // Update and sweep
    assign top      = r_lo + ph;
    assign wr_done  = (r_run == pw - CW'(1));
    assign clr_done = (r_addr == CW'(TEX_WIDTH - 1));

    srp_ram #(
        .WIDTH (HW),
        .DEPTH (TEX_WIDTH)
    ) u_sky (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write || i_cmd.clear),
        .i_waddr (r_addr[AW-1:0]),
        .i_wdata (i_cmd.write ? top : '0),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err    <= ST_OK;
            r_uh     <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan && addr_in;
            r_rd_idx <= r_addr[AW-1:0];

            if (i_cmd.accept) begin
                r_w    <= i_rect_width;
                r_h    <= i_rect_height;
                r_last <= i_last;
                r_px   <= '0;
                r_py   <= '0;
                r_act  <= 1'b0;
                r_ah   <= '0;
            end

            if (i_cmd.decide) begin
                if (!skip && bad) r_err <= ST_INVALID;
                r_lo   <= '0;
                r_hi   <= hi_init;
                r_have <= 1'b0;
            end

            if (i_cmd.start_pass) begin
                r_addr <= '0;
                r_run  <= '0;
            end

            // One column per cycle, leftmost fitting run ends the pass
            if (i_cmd.scan) begin
                if (addr_in) r_addr <= r_addr + CW'(1);
                if (r_rd_vld) r_run <= le ? run_inc : '0;
                if (hit) begin
                    r_hi     <= mid;
                    r_best_x <= hit_x;
                    r_have   <= 1'b1;
                end
                if (pass_end) r_lo <= mid + HW'(1);
            end

            if (i_cmd.set_exh) r_err <= ST_EXHAUSTED;

            if (i_cmd.wr_init) begin
                r_addr <= CW'(r_best_x);
                r_run  <= '0;
            end

            // Raise the skyline under the placed window
            if (i_cmd.write) begin
                r_addr <= r_addr + CW'(1);
                r_run  <= run_inc;
                if (wr_done) begin
                    if (top > r_uh) r_uh <= top;
                    r_px  <= PX_W'(32'(r_best_x) + 32'd1);
                    r_py  <= PY_W'(32'(r_lo) + 32'd1);
                    r_act <= 1'b1;
                end
            end

            if (i_cmd.clear) r_addr <= r_addr + CW'(1);

            if (i_cmd.fin) begin
                if (r_last && r_err == ST_OK && r_uh == '0) r_err <= ST_INVALID;
                r_pow <= (HW+1)'(MIN_TEX_HEIGHT);
            end

            // Round the used height up to a power of two, one doubling a cycle
            if (i_cmd.pow) begin
                if (r_pow < {1'b0, r_uh}) begin
                    r_pow <= r_pow << 1;
                end else if (32'(r_pow) > 32'(MAX_HEIGHT)) begin
                    r_err <= ST_EXHAUSTED;
                end else begin
                    r_ah <= AH_W'(r_pow);
                end
            end

            // Result word register
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
                r_opx    <= r_px;
                r_opy    <= r_py;
                r_oact   <= r_act;
                r_ost    <= r_err;
                r_oah    <= r_ah;
                r_olast  <= r_last;
                if (r_last) begin
                    r_uh   <= '0;
                    r_err  <= ST_OK;
                    r_addr <= '0;
                end
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.skip      = skip;
        o_sts.bad       = bad;
        o_sts.lo_lt_hi  = (r_lo < r_hi);
        o_sts.have      = r_have;
        o_sts.pass_done = hit || pass_end;
        o_sts.wr_done   = wr_done;
        o_sts.clr_done  = clr_done;
        o_sts.need_pow  = r_last && (r_err == ST_OK) && (r_uh != '0);
        o_sts.pow_done  = (r_pow >= {1'b0, r_uh});
        o_sts.out_busy  = r_ovalid && i_stall;
        o_sts.last      = r_last;
    end

    assign o_valid       = r_ovalid;
    assign o_place_x     = r_opx;
    assign o_place_y     = r_opy;
    assign o_active      = r_oact;
    assign o_status      = r_ost;
    assign o_tex_height  = r_oah;
    assign o_result_last = r_olast;

endmodule

// File: hw/rtl/skyline_rect_packer.sv
// Skyline rectangle packer: one rectangle in, one placement word out, one item
// at a time. The skyline lives in a RAM read one column per cycle. The lowest
// window height is found by a binary search over the height: each pass scans
// the columns once, stopping early when a fitting run is found, and there are
// up to clog2(MAX_HEIGHT) passes. Placing then writes the skyline update over
// the padded width. A last item adds height doubling for the atlas height and
// a clear sweep of the skyline RAM, which also runs after reset; no item is
// taken during a sweep. A finished word waits in the output register while the
// next item is taken.
`timescale 1ns / 1ps

module skyline_rect_packer #(
    parameter int TEX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [srp_pkg::IN_W-1:0]  i_rect_width,
    input  logic [srp_pkg::IN_W-1:0]  i_rect_height,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [srp_pkg::PX_W-1:0]  o_place_x,
    output logic [srp_pkg::PY_W-1:0]  o_place_y,
    output logic                      o_active,
    output logic [srp_pkg::ST_W-1:0]  o_status,
    output logic [srp_pkg::AH_W-1:0]  o_tex_height,
    output logic                      o_result_last
);
    import srp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    srp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    srp_dp #(
        .TEX_WIDTH  (TEX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_last        (i_last),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_place_x     (o_place_x),
        .o_place_y     (o_place_y),
        .o_active      (o_active),
        .o_status      (o_status),
        .o_tex_height  (o_tex_height),
        .o_result_last (o_result_last)
    );

endmodule

// File: hw/rtl/srp_checker.sv
// Port-level checks of the skyline packer, bound to the top level.
// Uses srp_pkg.
`timescale 1ns / 1ps

module srp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [srp_pkg::PX_W-1:0]  o_place_x,
    input logic [srp_pkg::PY_W-1:0]  o_place_y,
    input logic                      o_active,
    input logic [srp_pkg::ST_W-1:0]  o_status,
    input logic [srp_pkg::AH_W-1:0]  o_tex_height,
    input logic                      o_result_last
);
    import srp_pkg::*;

    // A held word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    // One item at a time: an accepted word closes the input
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while busy");

    // Skipped or failed words carry no position
    a_inact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_active |-> (o_place_x == '0) && (o_place_y == '0))
        else $error("inactive word with a position");

    // A placed word means no batch error so far
    a_act_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_active |-> (o_status == ST_OK))
        else $error("placed word with error status");

    // Atlas height only on a clean last word
    a_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_tex_height != '0) |-> o_result_last && (o_status == ST_OK))
        else $error("atlas height on wrong word");

endmodule

bind skyline_rect_packer srp_checker u_srp_checker (.*);

// File: tb/tb_skyline_rect_packer.sv
// Testbench for the skyline rectangle packer: random and directed rectangle batches,
// a behavioral placement predictor and an in-order result scoreboard.
// Depends on srp_pkg and skyline_rect_packer.
`timescale 1ns / 1ps

// Expected placement words, checked in order
class placement_board;
    typedef struct {
        logic [9:0]  px;
        logic [11:0] py;
        logic        act;
        logic [1:0]  st;
        logic [12:0] ah;
        logic        lst;
    } t_place;

    t_place pending[$];
    int     errors;

    // Packer state mirrored from the block
    int unsigned sky[1024];
    int unsigned used;
    logic [1:0]  berr;

    function new();
        errors = 0;
        clear_batch();
    endfunction

    function void clear_batch();
        foreach (sky[i]) sky[i] = 0;
        used = 0;
        berr = srp_pkg::ST_OK;
    endfunction

    // Work out the placement word for one accepted rectangle
    function void note_rect(int unsigned w, int unsigned h, bit lst);
        t_place      r;
        int unsigned pw, ph, bx, by, y, hh;
        bit          found;
        r.px = '0; r.py = '0; r.act = 1'b0; r.ah = '0; r.lst = lst;
        if (berr == srp_pkg::ST_OK && !(w == 0 && h == 0)) begin
            if (w == 0 || h == 0 || w > 1022 || h > 4094) begin
                berr = srp_pkg::ST_INVALID;
            end else begin
                pw = w + 2; ph = h + 2; found = 0; bx = 0; by = 0;
                for (int x = 0; x + pw <= 1024; x++) begin
                    y = 0;
                    for (int c = 0; c < pw; c++)
                        if (sky[x + c] > y) y = sky[x + c];
                    if (!found || y < by) begin
                        found = 1; bx = x; by = y;
                    end
                end
                if (!found || by + ph > 4096) begin
                    berr = srp_pkg::ST_EXHAUSTED;
                end else begin
                    for (int c = 0; c < pw; c++) sky[bx + c] = by + ph;
                    if (by + ph > used) used = by + ph;
                    r.px = 10'(bx + 1); r.py = 12'(by + 1); r.act = 1'b1;
                end
            end
        end
        if (lst && berr == srp_pkg::ST_OK) begin
            if (used == 0) begin
                berr = srp_pkg::ST_INVALID;
            end else begin
                hh = 1;
                while (hh < ((used < 64) ? 64 : used)) hh <<= 1;
                if (hh > 4096) berr = srp_pkg::ST_EXHAUSTED;
                else r.ah = 13'(hh);
            end
        end
        r.st = berr;
        pending.push_back(r);
        if (lst) clear_batch();
    endfunction

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_word(logic [9:0] px, logic [11:0] py, logic act, logic [1:0] st,
                    logic [12:0] ah, logic lst);
        t_place e;
        if (pending.size() == 0) begin
            report("unexpected word", 1, 0);
            return;
        end
        e = pending.pop_front();
        if (px !== e.px) report("place_x", px, e.px);
        if (py !== e.py) report("place_y", py, e.py);
        if (act !== e.act) report("active", act, e.act);
        if (st !== e.st) report("status", st, e.st);
        if (ah !== e.ah) report("tex_height", ah, e.ah);
        if (lst !== e.lst) report("result_last", lst, e.lst);
    endtask
endclass

module tb_skyline_rect_packer;
    logic        i_clk, i_rst_n, i_valid, i_stall, i_last;
    logic [15:0] i_rect_width, i_rect_height;
    logic        o_stall, o_valid, o_active, o_result_last;
    logic [9:0]  o_place_x;
    logic [11:0] o_place_y;
    logic [1:0]  o_status;
    logic [12:0] o_tex_height;

    placement_board board;
    int  send_idle, recv_idle;
    longint cycles = 0;

    skyline_rect_packer DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: random stall, check at rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_word(o_place_x, o_place_y, o_active, o_status,
                             o_tex_height, o_result_last);
    end
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle);
    end

    // Timeout watch
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 40000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one rectangle word and wait for its acceptance
    task send_rect(int unsigned w, int unsigned h, bit lst);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_rect_width <= 16'(w); i_rect_height <= 16'(h); i_last <= lst;
        do @(posedge i_clk); while (o_stall);
        board.note_rect(w, h, lst);
        @(negedge i_clk);
    endtask

    // Mostly small rectangles, some large or bad
    task random_rect(bit lst);
        int unsigned w, h, k;
        k = $urandom_range(99);
        if (k < 80) begin
            w = $urandom_range(1, 120); h = $urandom_range(1, 120);
        end else if (k < 88) begin
            w = $urandom_range(1, 1022); h = $urandom_range(1, 4094);
        end else if (k < 94) begin
            w = $urandom & 16'hffff; h = $urandom & 16'hffff;
        end else if (k < 97) begin
            w = 0; h = 0;
        end else begin
            w = $urandom_range(1) ? 0 : $urandom_range(1, 50);
            h = (w == 0) ? $urandom_range(1, 50) : 0;
        end
        send_rect(w, h, lst);
    endtask

    initial begin
        int n;
        board = new();
        i_valid = 0; i_last = 0;
        i_rect_width = 0; i_rect_height = 0;
        i_rst_n = 0;
        send_idle = 16; recv_idle = 77;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extremes, skips, errors, empty and oversized batches
        send_rect(0, 0, 1);
        send_rect(1, 1, 1);
        send_rect(1022, 4094, 1);
        send_rect(1023, 5, 0); send_rect(4, 4, 1);
        send_rect(5, 4095, 1);
        send_rect(16'hffff, 16'hffff, 1);
        send_rect(0, 7, 1);
        send_rect(9, 0, 1);
        send_rect(10, 10, 0); send_rect(0, 0, 0); send_rect(20, 30, 1);
        send_rect(1022, 3000, 0); send_rect(1022, 2000, 1);
        send_rect(1000, 2100, 0); send_rect(1000, 2100, 1);
        send_rect(500, 62, 0); send_rect(500, 62, 0); send_rect(3, 3, 1);
        send_rect(16'haaaa, 16'h5555, 1);
        send_rect(16'h0155, 16'h0aaa, 1);

        // Random batches in three idling phases
        n = 0;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle = 77; recv_idle = 16; end
            if (ph == 2) begin send_idle = 0; recv_idle = 0; end
            while (n < 180 * (ph + 1)) begin
                random_rect($urandom_range(99) < 12);
                n++;
            end
        end
        send_rect(7, 7, 1);
        i_valid <= 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
